### rtl/ssl_pkg.sv
// shared types and constants for the segment stream lexer
`default_nettype none

package ssl_pkg;

	// one result beat of the lexer
	typedef struct packed {
		logic        segment_end;
		logic        is_fixed;
		logic        is_variable;
		logic        id_known;
		logic        length_known;
		logic        in_data;
		logic [15:0] char_code;
		logic [7:0]  seg_id_out;
		logic [31:0] seg_length_out;
	} seg_result_t;

	// bit positions in the segment flag vector
	localparam int unsigned FlagFixed    = 0;
	localparam int unsigned FlagVariable = 1;
	localparam int unsigned FlagId       = 2;
	localparam int unsigned FlagLength   = 3;
	localparam int unsigned FlagData     = 4;
	localparam int unsigned FlagCount    = 5;

	localparam logic [7:0]  EscByte     = 8'hFF;
	localparam logic [7:0]  VarIdMask   = 8'h80;
	localparam logic [15:0] LongLenEsc  = 16'hFFFF;

endpackage

`default_nettype wire

### rtl/ssl_if.sv
// valid/ready channel interfaces for the byte input and the result output
`default_nettype none

interface ssl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

interface ssl_result_if;
	logic                valid;
	logic                ready;
	ssl_pkg::seg_result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/segment_stream_lexer.sv
// Byte-serial lexer for a little-endian segmented document stream. One byte is
// taken per beat and every byte yields exactly one result beat, which appears in
// the output register on the cycle after the byte is accepted. The parser state
// and the result register both update on the accepting clock edge, so a new byte
// is accepted in every cycle while the result register is empty or its beat is
// being taken; the sustained rate is one byte per clock while the output does not
// stall. The longest path is the 32-bit increment and compare of the payload byte counter.
`default_nettype none

module segment_stream_lexer (
	input  wire              clk,
	input  wire              arst_n,
	ssl_byte_if.sink         bytes,
	ssl_result_if.source     results
);

	typedef enum logic [3:0] {
		PH_ID     = 4'd0,
		PH_SECOND = 4'd1,
		PH_SLEN0  = 4'd2,
		PH_SLEN1  = 4'd3,
		PH_LLEN0  = 4'd4,
		PH_LLEN1  = 4'd5,
		PH_LLEN2  = 4'd6,
		PH_LLEN3  = 4'd7,
		PH_DATA   = 4'd8
	} phase_t;

	phase_t                         phase_q, phase_d;
	logic [7:0]                     held_id_q, held_id_d;
	logic [31:0]                    pay_len_q, pay_len_d;
	logic [31:0]                    seen_q, seen_d;
	logic [ssl_pkg::FlagCount-1:0]  flags_q, flags_d;
	logic [15:0]                    last_char_q, last_char_d;
	logic [7:0]                     last_id_q, last_id_d;
	logic [31:0]                    last_len_q, last_len_d;
	logic                           seg_end_d;
	logic [15:0]                    short_len;
	logic [31:0]                    seen_inc;

	logic                           res_valid_q;
	ssl_pkg::seg_result_t           res_q, res_d;
	logic                           accept;

	// handshake: take a byte whenever the result register can be refilled
	assign bytes.ready   = !res_valid_q || results.ready;
	assign accept        = bytes.valid && bytes.ready;
	assign results.valid = res_valid_q;
	assign results.data  = res_q;

	assign short_len = {bytes.data_byte, pay_len_q[7:0]};
	assign seen_inc  = seen_q + 32'd1;

	// next parser state for the incoming byte
	always_comb begin
		phase_d     = phase_q;
		held_id_d   = held_id_q;
		pay_len_d   = pay_len_q;
		seen_d      = seen_q;
		flags_d     = flags_q;
		last_char_d = last_char_q;
		last_id_d   = last_id_q;
		last_len_d  = last_len_q;
		seg_end_d   = 1'b0;
		case (phase_q)
			PH_SECOND: begin
				if (bytes.data_byte == ssl_pkg::EscByte &&
				    (held_id_q & ssl_pkg::VarIdMask) == ssl_pkg::VarIdMask) begin
					phase_d                        = PH_SLEN0;
					flags_d                        = '0;
					flags_d[ssl_pkg::FlagVariable] = 1'b1;
					flags_d[ssl_pkg::FlagId]       = 1'b1;
					last_id_d                      = held_id_q;
				end else begin
					phase_d                     = PH_ID;
					seg_end_d                   = 1'b1;
					flags_d                     = '0;
					flags_d[ssl_pkg::FlagFixed] = 1'b1;
					last_char_d                 = {bytes.data_byte, held_id_q};
				end
			end
			PH_SLEN0: begin
				pay_len_d = {24'd0, bytes.data_byte};
				phase_d   = PH_SLEN1;
			end
			PH_SLEN1: begin
				pay_len_d = {16'd0, short_len};
				if (short_len == 16'd0) begin
					// empty segment ends on its last length byte
					phase_d                      = PH_ID;
					seg_end_d                    = 1'b1;
					flags_d[ssl_pkg::FlagLength] = 1'b1;
					last_id_d                    = held_id_q;
					last_len_d                   = '0;
				end else if (short_len == ssl_pkg::LongLenEsc) begin
					phase_d = PH_LLEN0;
				end else begin
					phase_d                      = PH_DATA;
					seen_d                       = '0;
					flags_d[ssl_pkg::FlagLength] = 1'b1;
					last_id_d                    = held_id_q;
					last_len_d                   = {16'd0, short_len};
				end
			end
			PH_LLEN0: begin
				pay_len_d = {24'd0, bytes.data_byte};
				phase_d   = PH_LLEN1;
			end
			PH_LLEN1: begin
				pay_len_d[15:8] = bytes.data_byte;
				phase_d         = PH_LLEN2;
			end
			PH_LLEN2: begin
				pay_len_d[23:16] = bytes.data_byte;
				phase_d          = PH_LLEN3;
			end
			PH_LLEN3: begin
				pay_len_d[31:24]             = bytes.data_byte;
				phase_d                      = PH_DATA;
				seen_d                       = '0;
				flags_d[ssl_pkg::FlagLength] = 1'b1;
				last_id_d                    = held_id_q;
				last_len_d                   = {bytes.data_byte, pay_len_q[23:0]};
			end
			PH_DATA: begin
				// a zero long length wraps the counter before it matches
				flags_d[ssl_pkg::FlagData] = 1'b1;
				seen_d                     = seen_inc;
				if (seen_inc == pay_len_q) begin
					phase_d   = PH_ID;
					seg_end_d = 1'b1;
				end
			end
			default: begin
				held_id_d = bytes.data_byte;
				phase_d   = PH_SECOND;
				flags_d   = '0;
			end
		endcase
	end

	// result fields, masked by the flags they depend on
	always_comb begin
		res_d.segment_end    = seg_end_d;
		res_d.is_fixed       = flags_d[ssl_pkg::FlagFixed];
		res_d.is_variable    = flags_d[ssl_pkg::FlagVariable];
		res_d.id_known       = flags_d[ssl_pkg::FlagId];
		res_d.length_known   = flags_d[ssl_pkg::FlagLength];
		res_d.in_data        = flags_d[ssl_pkg::FlagData];
		res_d.char_code      = flags_d[ssl_pkg::FlagFixed] ? last_char_d : '0;
		res_d.seg_id_out     = flags_d[ssl_pkg::FlagId] ? last_id_d : '0;
		res_d.seg_length_out = flags_d[ssl_pkg::FlagLength] ? last_len_d : '0;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ID;
			held_id_q   <= '0;
			pay_len_q   <= '0;
			seen_q      <= '0;
			flags_q     <= '0;
			last_char_q <= '0;
			last_id_q   <= '0;
			last_len_q  <= '0;
		end else if (accept) begin
			phase_q     <= phase_d;
			held_id_q   <= held_id_d;
			pay_len_q   <= pay_len_d;
			seen_q      <= seen_d;
			flags_q     <= flags_d;
			last_char_q <= last_char_d;
			last_id_q   <= last_id_d;
			last_len_q  <= last_len_d;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_d;
		end
	end

	// every accepted byte shows up as a result beat on the next cycle
	a_accept_gives_beat: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> results.valid)
		else $error("accepted byte produced no result beat");

	// a segment is never both fixed and variable
	a_kind_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> !(results.data.is_fixed && results.data.is_variable))
		else $error("segment flagged both fixed and variable");

	// payload bytes only appear after the length is known
	a_data_needs_length: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.data.in_data |-> results.data.length_known)
		else $error("payload byte reported before length known");

	// in the payload phase the length and variable flags are always set
	a_data_phase_length: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> flags_q[ssl_pkg::FlagLength] && flags_q[ssl_pkg::FlagVariable])
		else $error("payload phase without variable length segment");

endmodule

`default_nettype wire
